>>> hdl/pidl_pkg.sv
package pidl_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int WORD_W       = 32;
	localparam int POS_W        = 6;
	localparam int OCC_W        = 6;

	localparam logic [2:0] KIND_APPEND      = 3'd0;
	localparam logic [2:0] KIND_REMOVE_LAST = 3'd1;
	localparam logic [2:0] KIND_INS_FRONT   = 3'd2;
	localparam logic [2:0] KIND_REM_FRONT   = 3'd3;
	localparam logic [2:0] KIND_INS_AT      = 3'd4;
	localparam logic [2:0] KIND_REM_AT      = 3'd5;
	localparam logic [2:0] KIND_DUMP        = 3'd6;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [2:0]               kind;
		logic signed [WORD_W-1:0] value;
		logic [POS_W-1:0]         position;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] data;
		logic [OCC_W-1:0]         occupancy;
		logic                     last;
	} rsp_word_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic step;
	} ctl_t;

	typedef struct packed {
		logic res_last;
	} dp_stat_t;

endpackage

>>> hdl/pidl_ctrl.sv
module pidl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  pidl_pkg::dp_stat_t  stat,
	output pidl_pkg::ctl_t      ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} state_t;

	state_t state_q;
	logic   cmd_ready_q;
	logic   rsp_valid_q;

	assign cmd_ready = cmd_ready_q;
	assign rsp_valid = rsp_valid_q;

	assign ctl.capture = cmd_valid & cmd_ready_q;
	assign ctl.exec    = (state_q == S_EXEC);
	// A dump advances to its next word in the same cycle the current one is taken.
	assign ctl.step    = rsp_valid_q & rsp_ready & ~stat.res_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_ready_q <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready_q) begin
						state_q     <= S_EXEC;
						cmd_ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					state_q     <= S_OUT;
					rsp_valid_q <= 1'b1;
				end
				S_OUT: begin
					if (rsp_ready && stat.res_last) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b0;
						cmd_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b0;
					cmd_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

>>> hdl/pidl_dp.sv
module pidl_dp #(
	parameter int CAPACITY = pidl_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pidl_pkg::cmd_word_t cmd,
	input  pidl_pkg::ctl_t      ctl,
	output pidl_pkg::dp_stat_t  stat,
	output pidl_pkg::rsp_word_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = ((CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W) + 1;

	pidl_pkg::cmd_word_t               cmd_q;
	logic signed [pidl_pkg::WORD_W-1:0] cells_q [CAPACITY];
	logic signed [pidl_pkg::WORD_W-1:0] cells_d [CAPACITY];
	logic [CW-1:0]                      count_q;
	logic [CW-1:0]                      dump_left_q;
	pidl_pkg::rsp_word_t                res_q;

	logic          full;
	logic          empty;
	logic [PW-1:0] count_e;
	logic [PW-1:0] pos_e;
	logic [PW-1:0] pos_m1;
	logic          do_ins;
	logic          do_rem;
	logic          do_rot;
	logic [IW-1:0] ins_idx;
	logic [IW-1:0] rem_idx;
	logic [CW-1:0] count_n;
	pidl_pkg::rsp_word_t exec_res;

	assign full    = (count_q >= CW'(CAPACITY));
	assign empty   = (count_q == '0);
	assign count_e = PW'(count_q);
	assign pos_e   = PW'(cmd_q.position);
	assign pos_m1  = pos_e - PW'(1);

	always_comb begin
		do_ins  = 1'b0;
		do_rem  = 1'b0;
		do_rot  = 1'b0;
		ins_idx = '0;
		rem_idx = '0;
		count_n = count_q;
		exec_res.status = pidl_pkg::ST_OK;
		exec_res.data   = '0;
		exec_res.last   = 1'b1;
		unique case (cmd_q.kind)
			pidl_pkg::KIND_APPEND: begin
				ins_idx = IW'(count_q);
				if (full) exec_res.status = pidl_pkg::ST_FULL;
				else      do_ins = 1'b1;
			end
			pidl_pkg::KIND_INS_FRONT: begin
				if (full) exec_res.status = pidl_pkg::ST_FULL;
				else      do_ins = 1'b1;
			end
			pidl_pkg::KIND_INS_AT: begin
				ins_idx = pos_m1[IW-1:0];
				if (full) exec_res.status = pidl_pkg::ST_FULL;
				else if (pos_e == '0 || pos_e > count_e + PW'(1))
					exec_res.status = pidl_pkg::ST_BADPOS;
				else do_ins = 1'b1;
			end
			pidl_pkg::KIND_REMOVE_LAST: begin
				rem_idx = IW'(count_q - CW'(1));
				if (empty) exec_res.status = pidl_pkg::ST_EMPTY;
				else       do_rem = 1'b1;
			end
			pidl_pkg::KIND_REM_FRONT: begin
				if (empty) exec_res.status = pidl_pkg::ST_EMPTY;
				else       do_rem = 1'b1;
			end
			pidl_pkg::KIND_REM_AT: begin
				rem_idx = pos_m1[IW-1:0];
				if (empty) exec_res.status = pidl_pkg::ST_EMPTY;
				else if (pos_e == '0 || pos_e > count_e)
					exec_res.status = pidl_pkg::ST_BADPOS;
				else do_rem = 1'b1;
			end
			pidl_pkg::KIND_DUMP: begin
				if (empty) exec_res.status = pidl_pkg::ST_EMPTY;
				else begin
					do_rot        = 1'b1;
					exec_res.data = cells_q[0];
					exec_res.last = (count_q == CW'(1));
				end
			end
			default: begin
			end
		endcase
		if (do_ins) count_n = count_q + CW'(1);
		if (do_rem) begin
			count_n       = count_q - CW'(1);
			exec_res.data = cells_q[rem_idx];
		end
		exec_res.occupancy = pidl_pkg::OCC_W'(count_n);
	end

	// Each cell takes from a neighbor, so an edit or dump step moves all cells at once.
	// A dump rotates the occupied cells once per word, which leaves them in order at the end.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cells_d[i] = cells_q[i];
			if (ctl.exec && do_ins) begin
				if (IW'(i) == ins_idx)     cells_d[i] = cmd_q.value;
				else if (IW'(i) > ins_idx) cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
			end else if (ctl.exec && do_rem) begin
				if (IW'(i) >= rem_idx && i < CAPACITY - 1)
					cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
			end else if ((ctl.exec && do_rot) || ctl.step) begin
				if (PW'(i + 1) < count_e)
					cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
				else if (PW'(i + 1) == count_e)
					cells_d[i] = cells_q[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) cmd_q <= cmd;
		for (int i = 0; i < CAPACITY; i++) cells_q[i] <= cells_d[i];
		if (ctl.exec) begin
			res_q <= exec_res;
		end else if (ctl.step) begin
			res_q.data <= cells_q[0];
			res_q.last <= (dump_left_q == CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dump_left_q <= '0;
		end else begin
			if (ctl.exec) begin
				count_q     <= count_n;
				dump_left_q <= count_q - CW'(1);
			end else if (ctl.step) begin
				dump_left_q <= dump_left_q - CW'(1);
			end
		end
	end

	assign stat.res_last = res_q.last;
	assign rsp           = res_q;

endmodule

>>> hdl/positional_insert_delete_list_core.sv
// After a command word is accepted, the controller passes through S_EXEC, where the result
// is registered, to S_OUT, where the first result word is presented until it is taken.
// No new command word is taken until the last result word is taken; a dump of N elements
// rotates the chain once in S_EXEC and once more as each word before the last is taken.
// Every edit shifts the cell chain at once, so the cost does not depend on the position.
// Reset (arst_n low) empties the list and the controller; stored words are not cleared.
module positional_insert_delete_list_core #(
	parameter int CAPACITY = pidl_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  pidl_pkg::cmd_word_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output pidl_pkg::rsp_word_t rsp
);

	pidl_pkg::ctl_t     ctl;
	pidl_pkg::dp_stat_t stat;

	pidl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	pidl_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.stat   (stat),
		.rsp    (rsp)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_ready && rsp_valid))
		else $error("command taken while a result word is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("ready stayed high after a command word was accepted");

	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != pidl_pkg::ST_OK |-> rsp.last && rsp.data == '0)
		else $error("rejected command gave more than one word or nonzero data");

endmodule

>>> tb/tb_positional_insert_delete_list_core.sv
module tb_positional_insert_delete_list_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP           = pidl_pkg::CAPACITY_DEF;
	localparam int WORD_W        = pidl_pkg::WORD_W;
	localparam int POS_W         = pidl_pkg::POS_W;
	localparam int OCC_W         = pidl_pkg::OCC_W;
	localparam int HALF_PERIOD   = 10;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS   = 30;
	localparam int MAX_REPORTS   = 10;

	// The one kind code the block leaves unused; it must answer like a no-op.
	localparam logic [2:0] KIND_NOP = 3'd7;

	typedef struct {
		pidl_pkg::cmd_word_t w;
		bit                  typed;
		pidl_pkg::rsp_word_t r;
	} stim_row_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_ready;
	pidl_pkg::cmd_word_t cmd       = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	pidl_pkg::rsp_word_t rsp;

	logic signed [WORD_W-1:0] list_mem [CAP];
	int                  list_len = 0;
	pidl_pkg::rsp_word_t awaited_words[$];
	stim_row_t           directed_rows[$];

	int idle_pct      = 0;
	int stall_pct     = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int errors        = 0;
	int words_checked = 0;
	int cmds_sent     = 0;
	int full_hits     = 0;
	int empty_hits    = 0;
	int badpos_hits   = 0;
	int dump_words    = 0;

	int phase_idle  [4] = '{0, 60, 0, 15};
	int phase_stall [4] = '{0, 0, 60, 15};
	int phase_grow  [4] = '{100, 15, 85, 50};

	positional_insert_delete_list_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	function automatic void queue_result(logic [1:0] st, logic signed [WORD_W-1:0] d, logic lst);
		pidl_pkg::rsp_word_t r;
		r.status    = st;
		r.data      = d;
		r.occupancy = OCC_W'(list_len);
		r.last      = lst;
		awaited_words.insert(awaited_words.size(), r);
		case (st)
			pidl_pkg::ST_FULL: full_hits++;
			pidl_pkg::ST_EMPTY: empty_hits++;
			pidl_pkg::ST_BADPOS: badpos_hits++;
			default: ;
		endcase
	endfunction

	function automatic void list_put(int idx, logic signed [WORD_W-1:0] w);
		for (int i = list_len; i > idx; i--)
			list_mem[i] = list_mem[i-1];
		list_mem[idx] = w;
		list_len++;
	endfunction

	function automatic logic signed [WORD_W-1:0] list_take(int idx);
		logic signed [WORD_W-1:0] w;
		w = list_mem[idx];
		for (int i = idx; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i+1];
		list_len--;
		return w;
	endfunction

	// Applies one command word to the shadow list and queues the words it should produce.
	function automatic void list_execute(pidl_pkg::cmd_word_t c);
		logic [1:0]               st;
		logic signed [WORD_W-1:0] d;
		int                       p;
		st = pidl_pkg::ST_OK;
		d  = '0;
		p  = int'(c.position);
		case (c.kind)
			pidl_pkg::KIND_APPEND: begin
				if (list_len >= CAP) st = pidl_pkg::ST_FULL;
				else list_put(list_len, c.value);
			end
			pidl_pkg::KIND_REMOVE_LAST: begin
				if (list_len == 0) st = pidl_pkg::ST_EMPTY;
				else d = list_take(list_len - 1);
			end
			pidl_pkg::KIND_INS_FRONT: begin
				if (list_len >= CAP) st = pidl_pkg::ST_FULL;
				else list_put(0, c.value);
			end
			pidl_pkg::KIND_REM_FRONT: begin
				if (list_len == 0) st = pidl_pkg::ST_EMPTY;
				else d = list_take(0);
			end
			pidl_pkg::KIND_INS_AT: begin
				if (list_len >= CAP) st = pidl_pkg::ST_FULL;
				else if (p < 1 || p > list_len + 1) st = pidl_pkg::ST_BADPOS;
				else list_put(p - 1, c.value);
			end
			pidl_pkg::KIND_REM_AT: begin
				if (list_len == 0) st = pidl_pkg::ST_EMPTY;
				else if (p < 1 || p > list_len) st = pidl_pkg::ST_BADPOS;
				else d = list_take(p - 1);
			end
			pidl_pkg::KIND_DUMP: begin
				if (list_len == 0) begin
					queue_result(pidl_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < list_len; i++) begin
						queue_result(pidl_pkg::ST_OK, list_mem[i], i == list_len - 1);
						dump_words++;
					end
				end
				return;
			end
			default: ;
		endcase
		queue_result(st, d, 1'b1);
	endfunction

	function automatic stim_row_t mk_row(logic [2:0] k, logic signed [WORD_W-1:0] v, int p,
			bit typed = 1'b0, logic [1:0] st = pidl_pkg::ST_OK,
			logic signed [WORD_W-1:0] d = '0, int occ = 0);
		stim_row_t row;
		row.w.kind        = k;
		row.w.value       = v;
		row.w.position    = POS_W'(p);
		row.typed         = typed;
		row.r.status      = st;
		row.r.data        = d;
		row.r.occupancy   = OCC_W'(occ);
		row.r.last        = 1'b1;
		return row;
	endfunction

	function automatic void add_row(stim_row_t row);
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	function automatic logic signed [WORD_W-1:0] random_value();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic pidl_pkg::cmd_word_t random_cmd(int grow_pct);
		pidl_pkg::cmd_word_t c;
		int                  roll;
		roll       = $urandom_range(99);
		c.value    = random_value();
		c.position = POS_W'($urandom_range(63));
		if (roll < 8) begin
			c.kind = pidl_pkg::KIND_DUMP;
		end else if (roll < 11) begin
			c.kind = KIND_NOP;
		end else if ($urandom_range(99) < grow_pct) begin
			case ($urandom_range(2))
				0: c.kind = pidl_pkg::KIND_APPEND;
				1: c.kind = pidl_pkg::KIND_INS_FRONT;
				default: begin
					c.kind = pidl_pkg::KIND_INS_AT;
					if ($urandom_range(9) < 8)
						c.position = POS_W'($urandom_range(list_len + 1, 1));
				end
			endcase
		end else begin
			case ($urandom_range(2))
				0: c.kind = pidl_pkg::KIND_REMOVE_LAST;
				1: c.kind = pidl_pkg::KIND_REM_FRONT;
				default: begin
					c.kind = pidl_pkg::KIND_REM_AT;
					if (list_len > 0 && $urandom_range(9) < 8)
						c.position = POS_W'($urandom_range(list_len, 1));
				end
			endcase
		end
		return c;
	endfunction

	// Entered and left just after a falling edge; valid is left high for the next word.
	task automatic offer(input pidl_pkg::cmd_word_t w, input bit typed,
			input pidl_pkg::rsp_word_t r);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= w;
		do @(posedge clk); while (!cmd_ready);
		@(negedge clk);
		cmds_sent++;
		list_execute(w);
		if (typed) begin
			// The typed-in answer stands in for the computed one, so the row is checked on its own.
			awaited_words.delete(awaited_words.size() - 1);
			awaited_words.insert(awaited_words.size(), r);
		end
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (awaited_words.size() != 0);
	endtask

	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		pidl_pkg::rsp_word_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_words.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result word: status %0d data %0d occupancy %0d last %0b",
						rsp.status, rsp.data, rsp.occupancy, rsp.last);
			end else begin
				want = awaited_words.pop_front();
				words_checked++;
				if (rsp.status !== want.status || rsp.data !== want.data ||
						rsp.occupancy !== want.occupancy || rsp.last !== want.last) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("word %0d: expected status %0d data %0d occupancy %0d last %0b",
							words_checked, want.status, want.data, want.occupancy, want.last);
						$display("    got status %0d data %0d occupancy %0d last %0b",
							rsp.status, rsp.data, rsp.occupancy, rsp.last);
					end
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int n;
		int mark;

		// Empty list first: every removal and the dump report an empty list; inserts and removals follow.
		add_row(mk_row(pidl_pkg::KIND_DUMP, '0, 0, 1'b1, pidl_pkg::ST_EMPTY, '0, 0));
		add_row(mk_row(pidl_pkg::KIND_REMOVE_LAST, '0, 0, 1'b1, pidl_pkg::ST_EMPTY, '0, 0));
		add_row(mk_row(pidl_pkg::KIND_REM_FRONT, '0, 0, 1'b1, pidl_pkg::ST_EMPTY, '0, 0));
		add_row(mk_row(pidl_pkg::KIND_REM_AT, '0, 0, 1'b1, pidl_pkg::ST_EMPTY, '0, 0));
		add_row(mk_row(pidl_pkg::KIND_INS_AT, -1, 0, 1'b1, pidl_pkg::ST_BADPOS, '0, 0));
		add_row(mk_row(pidl_pkg::KIND_INS_AT, -1, 2, 1'b1, pidl_pkg::ST_BADPOS, '0, 0));
		add_row(mk_row(pidl_pkg::KIND_INS_AT, 32'sh7fff_ffff, 1, 1'b1, pidl_pkg::ST_OK, '0, 1));
		add_row(mk_row(pidl_pkg::KIND_APPEND, 32'sh8000_0000, 0, 1'b1, pidl_pkg::ST_OK, '0, 2));
		add_row(mk_row(pidl_pkg::KIND_INS_FRONT, -1, 0, 1'b1, pidl_pkg::ST_OK, '0, 3));
		add_row(mk_row(pidl_pkg::KIND_INS_AT, 5, 4, 1'b1, pidl_pkg::ST_OK, '0, 4));
		add_row(mk_row(pidl_pkg::KIND_INS_AT, 0, 2, 1'b1, pidl_pkg::ST_OK, '0, 5));
		add_row(mk_row(pidl_pkg::KIND_REM_AT, '0, 6, 1'b1, pidl_pkg::ST_BADPOS, '0, 5));
		add_row(mk_row(pidl_pkg::KIND_REM_AT, '0, 63, 1'b1, pidl_pkg::ST_BADPOS, '0, 5));
		add_row(mk_row(pidl_pkg::KIND_INS_AT, -1, 63, 1'b1, pidl_pkg::ST_BADPOS, '0, 5));
		add_row(mk_row(KIND_NOP, -1, 63, 1'b1, pidl_pkg::ST_OK, '0, 5));
		add_row(mk_row(pidl_pkg::KIND_DUMP, '0, 0));
		add_row(mk_row(pidl_pkg::KIND_REM_AT, '0, 3));
		add_row(mk_row(pidl_pkg::KIND_REM_FRONT, '0, 0));
		add_row(mk_row(pidl_pkg::KIND_REMOVE_LAST, '0, 0));
		add_row(mk_row(pidl_pkg::KIND_REM_AT, '0, 1));
		add_row(mk_row(pidl_pkg::KIND_DUMP, '0, 0));
		add_row(mk_row(pidl_pkg::KIND_REM_AT, '0, 1));

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			offer(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].r);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = phase_idle[ph];
			stall_pct = phase_stall[ph];
			// A long receiver hold while words keep coming backs the block up to its input.
			if (ph == 2)
				hold_requests++;
			mark = (ph == 0) ? full_hits : empty_hits;
			n    = 0;
			// Fill and drain phases go on until the list hits its limit, within a cap on items.
			while (n < PHASE_ITEMS ||
					(ph == 0 && full_hits == mark && n < 3 * PHASE_ITEMS) ||
					(ph == 1 && empty_hits == mark && n < 3 * PHASE_ITEMS)) begin
				offer(random_cmd(phase_grow[ph]), 1'b0, '0);
				n++;
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Ran %0d commands through fill, drain, stalled and mixed traffic.", cmds_sent);
		$display("%0d words checked, %0d from dumps; rejections: %0d full, %0d empty, %0d bad position.",
			words_checked, dump_words, full_hits, empty_hits, badpos_hits);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
